### src/assert_macros.svh
// Assertion macros used by the validator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included
`define ASV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/asv_pkg.sv
// Types, constants and the digit decoder for the address string validator
`timescale 1ns / 1ps

package asv_pkg;

    localparam logic       KIND_IPV4   = 1'b0;
    localparam logic       KIND_MAC    = 1'b1;

    localparam logic [2:0] IPV4_LAST_GROUP = 3'd3;
    localparam logic [2:0] MAC_LAST_GROUP  = 3'd5;
    localparam logic [1:0] IPV4_MAX_DIGITS = 2'd3;
    localparam logic [1:0] MAC_MAX_DIGITS  = 2'd2;
    localparam logic [8:0] GROUP_MAX       = 9'd255;

    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } t_digit;

    // Digit value of a character; hex letters count only in MAC mode
    function automatic t_digit digit_of(input logic [7:0] c, input logic mac);
        t_digit d;
        logic [7:0] off;
        d = '0;
        off = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            off = c - CHAR_ZERO;
            d.hit = 1'b1;
            d.value = off[3:0];
        end else if (mac && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            off = c - CHAR_UPPER_A + 8'd10;
            d.hit = 1'b1;
            d.value = off[3:0];
        end
        return d;
    endfunction

endpackage

### src/address_string_validator.sv
// Address string validator: IPv4 dotted decimal / uppercase MAC checker
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_char_code, i_last_char | request in
//  out     | o_out_valid, i_out_ready, o_is_valid_address     | request out
//  cfg     | i_cfg_wr_en, i_cfg_wr_data (address_kind)        | write only
//
// One character per cycle unless stalled; the result appears the cycle after its last char.
// Throughput is set by the single parse-state update, one char per clock unless stalled.
// The output register holds a result until taken; input stalls only when it is full and held.
// Synchronous active-low reset clears parse state, mode (IPv4) and the output valid flag.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module address_string_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_is_valid_address
);

    logic       r_address_kind;
    logic [2:0] r_group_index,    n_group_index;
    logic [1:0] r_digit_count,    n_digit_count;
    logic [8:0] r_group_value,    n_group_value;
    logic       r_first_digit_zero, n_first_digit_zero;
    logic       r_error_seen,     n_error_seen;
    logic       r_out_valid;
    logic       r_out_data,       n_out_data;

    logic            accept;
    logic            mac;
    asv_pkg::t_digit dig;
    logic [12:0]     scaled;
    logic [12:0]     acc;
    logic [1:0]      max_digits;
    logic [2:0]      last_group;
    logic [7:0]      sep;
    logic            group_ok;

    assign o_in_ready         = !r_out_valid || i_out_ready;
    assign accept             = i_in_valid && o_in_ready;
    assign o_out_valid        = r_out_valid;
    assign o_is_valid_address = r_out_data;

    assign mac        = (r_address_kind == asv_pkg::KIND_MAC);
    assign dig        = asv_pkg::digit_of(i_char_code, mac);
    assign max_digits = mac ? asv_pkg::MAC_MAX_DIGITS : asv_pkg::IPV4_MAX_DIGITS;
    assign last_group = mac ? asv_pkg::MAC_LAST_GROUP : asv_pkg::IPV4_LAST_GROUP;
    assign sep        = mac ? asv_pkg::CHAR_COLON : asv_pkg::CHAR_DOT;
    assign group_ok   = mac ? (r_digit_count == asv_pkg::MAC_MAX_DIGITS)
                            : (r_digit_count != 2'd0);

    // x16 for hex, x10 = x8 + x2 for decimal
    assign scaled = mac ? {r_group_value, 4'b0000}
                        : ({1'b0, r_group_value, 3'b000} + {3'b000, r_group_value, 1'b0});
    assign acc    = scaled + {9'd0, dig.value};

    always_comb begin
        n_group_index      = r_group_index;
        n_digit_count      = r_digit_count;
        n_group_value      = r_group_value;
        n_first_digit_zero = r_first_digit_zero;
        n_error_seen       = r_error_seen;
        n_out_data         = r_out_data;

        if (!r_error_seen) begin
            if (dig.hit) begin
                if (r_digit_count >= max_digits) begin
                    n_error_seen = 1'b1;
                end else if (!mac && r_digit_count != 2'd0 && r_first_digit_zero) begin
                    n_error_seen = 1'b1;   // leading zero in a decimal group
                end else if (acc > {4'd0, asv_pkg::GROUP_MAX}) begin
                    n_error_seen = 1'b1;
                end else begin
                    if (r_digit_count == 2'd0) begin
                        n_first_digit_zero = (dig.value == 4'd0);
                    end
                    n_group_value = acc[8:0];
                    n_digit_count = r_digit_count + 2'd1;
                end
            end else if (i_char_code == sep) begin
                if (!group_ok || r_group_index >= last_group) begin
                    n_error_seen = 1'b1;
                end else begin
                    n_group_index      = r_group_index + 3'd1;
                    n_digit_count      = 2'd0;
                    n_group_value      = 9'd0;
                    n_first_digit_zero = 1'b0;
                end
            end else begin
                n_error_seen = 1'b1;
            end
        end

        if (i_last_char) begin
            n_out_data = !n_error_seen && (n_group_index == last_group) &&
                         (mac ? (n_digit_count == asv_pkg::MAC_MAX_DIGITS)
                              : (n_digit_count != 2'd0));
            n_group_index      = 3'd0;
            n_digit_count      = 2'd0;
            n_group_value      = 9'd0;
            n_first_digit_zero = 1'b0;
            n_error_seen       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_kind     <= asv_pkg::KIND_IPV4;
            r_group_index      <= 3'd0;
            r_digit_count      <= 2'd0;
            r_group_value      <= 9'd0;
            r_first_digit_zero <= 1'b0;
            r_error_seen       <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_address_kind <= i_cfg_wr_data;
            end
            if (accept) begin
                r_group_index      <= n_group_index;
                r_digit_count      <= n_digit_count;
                r_group_value      <= n_group_value;
                r_first_digit_zero <= n_first_digit_zero;
                r_error_seen       <= n_error_seen;
            end
            if (accept && i_last_char) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && i_last_char) begin
            r_out_data <= n_out_data;
        end
    end

    `ASV_ASSERT(a_result_from_last,
        $rose(r_out_valid) |-> $past(accept && i_last_char),
        "result without a last character")
    `ASV_ASSERT(a_clear_after_last,
        (accept && i_last_char) |=>
            (r_group_index == 3'd0 && r_digit_count == 2'd0 && !r_error_seen),
        "parse state not cleared after string end")
    `ASV_ASSERT(a_group_value_bound,
        r_group_value <= asv_pkg::GROUP_MAX,
        "group value above 255")
    `ASV_ASSERT_ALWAYS(a_reset_clears_out,
        !i_rst_n |=> !r_out_valid,
        "result valid after reset")

endmodule

### tb/asv_checker.sv
// Verdict predictor and scoreboard for the address string validator
`timescale 1ns / 1ps

module asv_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  logic [7:0] i_char_code,
    input  logic i_last_char,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  logic i_is_valid_address,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_verdicts,
    output int   o_valid_verdicts
);

    logic       kind;
    logic [2:0] grp_idx;
    logic [1:0] dig_cnt;
    logic [8:0] grp_val;
    logic       lead_zero;
    logic       broken;
    bit         verdict_q[$];

    task automatic clear_parse();
        grp_idx = '0;
        dig_cnt = '0;
        grp_val = '0;
        lead_zero = 1'b0;
        broken = 1'b0;
    endtask

    // Advance the parse by one character; on the last one queue the verdict
    task automatic parse_char(input logic [7:0] c, input logic last);
        logic        mac;
        logic        is_digit;
        logic [3:0]  dval;
        logic [1:0]  cap;
        logic [2:0]  final_grp;
        logic [7:0]  sep;
        logic [11:0] nv;
        logic        group_ok;
        logic        ok;
        mac = (kind == asv_pkg::KIND_MAC);
        is_digit = 1'b0;
        dval = '0;
        if (c >= asv_pkg::CHAR_ZERO && c <= asv_pkg::CHAR_NINE) begin
            is_digit = 1'b1;
            dval = 4'(c - asv_pkg::CHAR_ZERO);
        end else if (mac && c >= asv_pkg::CHAR_UPPER_A && c <= asv_pkg::CHAR_UPPER_F) begin
            is_digit = 1'b1;
            dval = 4'(c - asv_pkg::CHAR_UPPER_A + 8'd10);
        end
        cap = mac ? asv_pkg::MAC_MAX_DIGITS : asv_pkg::IPV4_MAX_DIGITS;
        final_grp = mac ? asv_pkg::MAC_LAST_GROUP : asv_pkg::IPV4_LAST_GROUP;
        sep = mac ? asv_pkg::CHAR_COLON : asv_pkg::CHAR_DOT;
        nv = mac ? {grp_val[7:0], 4'b0} + 12'(dval) : 12'(grp_val) * 12'd10 + 12'(dval);

        if (!broken) begin
            if (is_digit) begin
                if (dig_cnt >= cap) begin
                    broken = 1'b1;
                end else if (!mac && dig_cnt != 0 && lead_zero) begin
                    broken = 1'b1;
                end else if (nv > 12'(asv_pkg::GROUP_MAX)) begin
                    broken = 1'b1;
                end else begin
                    if (dig_cnt == 0)
                        lead_zero = (dval == 0);
                    grp_val = nv[8:0];
                    dig_cnt = dig_cnt + 2'd1;
                end
            end else if (c == sep) begin
                group_ok = mac ? (dig_cnt == 2'd2) : (dig_cnt != 0);
                if (!group_ok || grp_idx >= final_grp) begin
                    broken = 1'b1;
                end else begin
                    grp_idx = grp_idx + 3'd1;
                    dig_cnt = '0;
                    grp_val = '0;
                    lead_zero = 1'b0;
                end
            end else begin
                broken = 1'b1;
            end
        end

        if (last) begin
            ok = !broken && grp_idx == final_grp
                 && (mac ? (dig_cnt == 2'd2) : (dig_cnt != 0));
            verdict_q.push_back(ok);
            clear_parse();
        end
    endtask

    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            kind = asv_pkg::KIND_IPV4;
            clear_parse();
            verdict_q.delete();
            o_fail_count <= 0;
            o_verdicts <= 0;
            o_valid_verdicts <= 0;
        end else begin
            if (i_cfg_wr_en)
                kind = i_cfg_wr_data;
            if (i_in_valid && i_in_ready)
                parse_char(i_char_code, i_last_char);
            if (i_out_valid && i_out_ready) begin
                o_verdicts <= o_verdicts + 1;
                if (i_is_valid_address === 1'b1)
                    o_valid_verdicts <= o_valid_verdicts + 1;
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, actual %0b",
                             $time, i_is_valid_address);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_is_valid_address !== want) begin
                        $display("%0t: is_valid_address mismatch, expected %0b, actual %0b",
                                 $time, want, i_is_valid_address);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= verdict_q.size();
    end

endmodule

### tb/tb_address_string_validator.sv
// Testbench top for the address string validator: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_address_string_validator;

    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_CHARS = 250;
    localparam int PHASES      = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_char_code = 8'h00;
    logic       i_last_char = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_is_valid_address;

    int fail_count;
    int pending;
    int verdicts;
    int valid_verdicts;
    int quiet_cycles = 0;
    int chars_sent = 0;
    int strings_sent = 0;
    int mode_switches = 0;
    bit calm = 1'b0;

    logic [7:0] text_q[$];

    address_string_validator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_char_code       (i_char_code),
        .i_last_char       (i_last_char),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_is_valid_address(o_is_valid_address)
    );

    asv_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_char_code       (i_char_code),
        .i_last_char       (i_last_char),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_is_valid_address(o_is_valid_address),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_verdicts        (verdicts),
        .o_valid_verdicts  (valid_verdicts)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 29);
    end

    // Any accepted request or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        chars_sent++;
        if (last)
            strings_sent++;
    endtask

    // Sends the first n characters of the text; the string ends only if n covers it all
    task automatic send_text(input int n);
        for (int i = 0; i < n; i++)
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic send_string(input string s);
        text_q.delete();
        add_text(s);
        send_text(text_q.size());
    endtask

    // Mode changes only once all verdicts are out and the parse has settled
    task automatic set_kind(input logic k);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= k;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        mode_switches++;
    endtask

    task automatic add_group(input logic mac);
        int v;
        case ($urandom_range(3))
            0: v = 0;
            1: v = 255;
            default: v = $urandom_range(255);
        endcase
        if (mac)
            add_text($sformatf("%02X", v));
        else
            add_text($sformatf("%0d", v));
    endtask

    task automatic build_address(input logic mac);
        text_q.delete();
        for (int g = 0; g < (mac ? 6 : 4); g++) begin
            if (g != 0)
                text_q.push_back(mac ? asv_pkg::CHAR_COLON : asv_pkg::CHAR_DOT);
            add_group(mac);
        end
    endtask

    // One random change, meant as a defect, into a well-formed address
    task automatic spoil_address(input logic mac);
        int pos;
        logic [7:0] sep;
        logic [7:0] trap;
        sep = mac ? asv_pkg::CHAR_COLON : asv_pkg::CHAR_DOT;
        pos = $urandom_range(text_q.size() - 1);
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(5))
                    0: trap = 8'h61 + 8'($urandom_range(5));   // lowercase hex
                    1: trap = mac ? asv_pkg::CHAR_DOT : asv_pkg::CHAR_COLON;
                    2: trap = 8'h20;
                    3: trap = $urandom_range(1) ? 8'h2B : 8'h2D;
                    4: trap = 8'h00;
                    default: trap = 8'($urandom_range(255));
                endcase
                text_q[pos] = trap;
            end
            1: text_q.insert(pos, asv_pkg::CHAR_ZERO + 8'($urandom_range(9)));
            2: if (text_q.size() > 1) text_q.delete(pos);
            3: begin
                text_q.push_back(sep);
                add_group(mac);
            end
            4: begin
                // drop the final group, sometimes keeping the dangling separator
                while (text_q.size() > 1 && text_q[$] != sep)
                    void'(text_q.pop_back());
                if ($urandom_range(1) && text_q.size() > 1)
                    void'(text_q.pop_back());
            end
            5: text_q.insert(0, asv_pkg::CHAR_ZERO);
            6: begin
                while (text_q.size() > 1 && text_q[$] != sep)
                    void'(text_q.pop_back());
                if (mac)
                    add_text($sformatf("%0X", $urandom_range(256, 4095)));
                else
                    add_text($sformatf("%0d", $urandom_range(256, 999)));
            end
            default: text_q.insert(pos, sep);
        endcase
    endtask

    task automatic build_noise();
        int n;
        text_q.delete();
        n = $urandom_range(1, 20);
        repeat (n) begin
            case ($urandom_range(3))
                0: text_q.push_back(8'($urandom_range(255)));
                1: text_q.push_back(asv_pkg::CHAR_ZERO + 8'($urandom_range(9)));
                2: text_q.push_back($urandom_range(1) ? asv_pkg::CHAR_DOT
                                                      : asv_pkg::CHAR_COLON);
                default: text_q.push_back(asv_pkg::CHAR_UPPER_A + 8'($urandom_range(5)));
            endcase
        end
    endtask

    initial begin
        int phase_start;
        int r;
        logic kind;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, leading zero, stray bytes, both modes
        set_kind(asv_pkg::KIND_IPV4);
        send_string("255.0.9.10");
        send_string("00");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        set_kind(asv_pkg::KIND_MAC);
        send_string("FF:00:9A:B0:12:3C");
        send_string("ab");

        for (int phase = 0; phase < PHASES; phase++) begin
            kind = (phase < 2) ? asv_pkg::KIND_IPV4 ^ logic'(phase == 0)
                               : logic'($urandom_range(1));
            set_kind(kind);
            calm = (phase == 3);
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                r = $urandom_range(99);
                if (r < 88) begin
                    build_address(kind);
                    if (r >= 55)
                        spoil_address(kind);
                end else begin
                    build_noise();
                end
                send_text(text_q.size());
            end
            // sometimes leave a string open across the mode change
            if (phase != PHASES - 1 && $urandom_range(1)) begin
                build_address(kind);
                send_text($urandom_range(1, text_q.size() - 1));
            end
        end
        calm = 1'b0;

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (5) @(negedge i_clk);

        $display("Sent %0d characters in %0d strings across %0d mode writes.",
                 chars_sent, strings_sent, mode_switches);
        $display("Checked %0d verdicts, %0d of them valid addresses.",
                 verdicts, valid_verdicts);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### address_string_validator.f
+incdir+src
src/asv_pkg.sv
src/address_string_validator.sv
tb/asv_checker.sv
tb/tb_address_string_validator.sv
